/* src/yrb_pkg.sv */
// ----------------------------------------------------------------------------
// yrb_pkg
// Shared constants, block kind codes and control structs for the 4:2:2
// raster-to-block converter.
// ----------------------------------------------------------------------------
package yrb_pkg;

  localparam int BLOCK_SIZE  = 8;
  localparam int MCU_WIDTH   = 16;
  localparam int STRIP_LINES = 8;
  localparam int SAMPLE_W    = 8;
  localparam int PIXEL_W     = 2 * SAMPLE_W;
  localparam int CFG_W       = 7;
  localparam int ROW_W       = 3;
  localparam int PHASE_W     = 4;
  localparam int LINE_W      = 3;
  localparam int KIND_W      = 2;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_Y_LEFT  = 2'd0;
  localparam kind_t KIND_Y_RIGHT = 2'd1;
  localparam kind_t KIND_U       = 2'd2;
  localparam kind_t KIND_V       = 2'd3;

  localparam logic [PHASE_W-1:0] PHASE_LEFT_DONE  = 4'd7;
  localparam logic [PHASE_W-1:0] PHASE_RIGHT_DONE = 4'd15;
  localparam logic [LINE_W-1:0]  LAST_LINE        = 3'd7;
  localparam logic [ROW_W-1:0]   LAST_ROW         = 3'd7;
  localparam logic [CFG_W-1:0]   CFG_RESET        = 7'd1;

  typedef struct packed {
    logic                 wr_en;
    logic                 rd_en;
    logic                 load;
    kind_t                kind;
    logic [ROW_W-1:0]     row;
    logic                 last;
  } yrb_cmd_t;

  typedef struct packed {
    logic trig_left;
    logic trig_right;
    logic out_free;
  } yrb_status_t;

endpackage

/* src/yuv422_raster_to_block.sv */
// Flow: a pixel that completes no block is only written into the strip store; the
// pixel that triggers a run starts a strip read, and each row read is loaded into
// the output register once that register is free. Throughput: one pixel per cycle
// between runs; a run takes a strip read and a load per row, 8 rows for Y-left and
// 24 for Y-right, U and V, and waits for each row's load before the next strip read.
// Reset (rst_n low at a clock edge) clears position, width (one MCU) and control.
// ----------------------------------------------------------------------------
// yuv422_raster_to_block
// Converts 4:2:2 raster pixels into 8x8 block rows per 16-pixel MCU.
// ----------------------------------------------------------------------------
module yuv422_raster_to_block #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // luma [7:0], chroma [15:8]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // row_byte_0 [7:0] up to row_byte_7 [63:56]
  output logic [4:0]  out_tuser,  // block_kind [1:0], row_index [4:2]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);

  import yrb_pkg::*;

  yrb_cmd_t    cmd;
  yrb_status_t status;

  assign cfg_ready = 1'b1;

  yrb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  yrb_dp #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

`ifndef ASSERT_OFF
  a_load_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_tvalid || out_tready))
    else $error("Output row loaded over an untaken row.");

  a_no_write_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> !cmd.rd_en && !cmd.load)
    else $error("Strip write during an emission run.");

  a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && status.trig_right) |=> !in_tready)
    else $error("Input taken right after a run was started.");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && cmd.last) |=> in_tready)
    else $error("Controller did not return to input after the last row.");
`endif

endmodule

/* src/yrb_ram.sv */
// ----------------------------------------------------------------------------
// yrb_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module yrb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/yrb_ctrl.sv */
// ----------------------------------------------------------------------------
// yrb_ctrl
// Controller: accepts pixels and sequences the block row reads and output
// loads of each emission run.
// ----------------------------------------------------------------------------
module yrb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  yrb_pkg::yrb_status_t status,
  output yrb_pkg::yrb_cmd_t    cmd
);

  import yrb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT
  } state_t;

  state_t           state_r, state_nxt;
  kind_t            kind_r, kind_nxt;
  kind_t            last_kind_r, last_kind_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             accept;
  logic             run_last;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign run_last  = (kind_r == last_kind_r) && (row_r == LAST_ROW);

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    last_kind_nxt = last_kind_r;
    row_nxt       = row_r;
    cmd           = '0;
    cmd.kind      = kind_r;
    cmd.row       = row_r;
    cmd.last      = run_last;
    case (state_r)
      ST_IDLE: begin
        cmd.wr_en = accept;
        if (accept && status.trig_left) begin
          kind_nxt      = KIND_Y_LEFT;
          last_kind_nxt = KIND_Y_LEFT;
          row_nxt       = '0;
          state_nxt     = ST_READ;
        end else if (accept && status.trig_right) begin
          kind_nxt      = KIND_Y_RIGHT;
          last_kind_nxt = KIND_V;
          row_nxt       = '0;
          state_nxt     = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (status.out_free) begin
          cmd.load = 1'b1;
          if (run_last) begin
            state_nxt = ST_IDLE;
          end else begin
            row_nxt   = row_r + 1'b1;
            if (row_r == LAST_ROW) begin
              kind_nxt = kind_r + 1'b1;
            end
            state_nxt = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      kind_r      <= KIND_Y_LEFT;
      last_kind_r <= KIND_Y_LEFT;
      row_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      last_kind_r <= last_kind_nxt;
      row_r       <= row_nxt;
    end
  end

endmodule

/* src/yrb_dp.sv */
// ----------------------------------------------------------------------------
// yrb_dp
// Datapath: raster position, width register, the strip store in sixteen
// column banks, block row selection and the output register.
// ----------------------------------------------------------------------------
module yrb_dp #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [15:0]          in_tdata,
  input  logic                 cfg_valid,
  input  logic [6:0]           cfg_data,
  input  yrb_pkg::yrb_cmd_t    cmd,
  output yrb_pkg::yrb_status_t status,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [63:0]          out_tdata,
  output logic [4:0]           out_tuser,
  output logic                 out_tlast
);

  import yrb_pkg::*;

  localparam int MAX_MCUS = MAX_WIDTH / MCU_WIDTH;
  localparam int MCU_W    = (MAX_MCUS > 1) ? $clog2(MAX_MCUS) : 1;
  localparam int CNT_W    = ($clog2(MAX_MCUS + 1) > CFG_W) ? $clog2(MAX_MCUS + 1) : CFG_W;
  localparam int DEPTH    = STRIP_LINES * MAX_MCUS;
  localparam int AW       = $clog2(DEPTH);

  logic [CFG_W-1:0]   cfg_r;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [MCU_W-1:0]   mcu_r, mcu_nxt;
  logic [LINE_W-1:0]  line_r, line_nxt;
  logic [MCU_W-1:0]   mcu_rd_r;
  logic [CNT_W-1:0]   eff_mcus;
  logic [CNT_W-1:0]   mcu_ext;
  logic               line_end;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;
  logic [PIXEL_W-1:0] bank_rdata [MCU_WIDTH];
  logic [63:0]        row_sel;
  logic               out_valid_r;
  logic [63:0]        out_data_r;
  logic [4:0]         out_user_r;
  logic               out_last_r;

  always_comb begin
    eff_mcus = CNT_W'(cfg_r);
    if (cfg_r == '0) begin
      eff_mcus = CNT_W'(1);
    end else if (CNT_W'(cfg_r) > CNT_W'(MAX_MCUS)) begin
      eff_mcus = CNT_W'(MAX_MCUS);
    end
  end

  assign mcu_ext  = CNT_W'(mcu_r);
  assign line_end = (mcu_ext >= eff_mcus) ||
                    ((mcu_ext + 1'b1 == eff_mcus) && (phase_r == PHASE_RIGHT_DONE));

  always_comb begin
    phase_nxt = phase_r;
    mcu_nxt   = mcu_r;
    line_nxt  = line_r;
    if (cmd.wr_en) begin
      if (line_end) begin
        phase_nxt = '0;
        mcu_nxt   = '0;
        line_nxt  = line_r + 1'b1;
      end else begin
        phase_nxt = phase_r + 1'b1;
        if (phase_r == PHASE_RIGHT_DONE) begin
          mcu_nxt = mcu_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r   <= CFG_RESET;
      phase_r <= '0;
      mcu_r   <= '0;
      line_r  <= '0;
    end else begin
      if (cfg_valid) begin
        cfg_r <= cfg_data;
      end
      phase_r <= phase_nxt;
      mcu_r   <= mcu_nxt;
      line_r  <= line_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mcu_rd_r <= mcu_r;
    end
  end

  assign status.trig_left  = (line_r == LAST_LINE) && (phase_r == PHASE_LEFT_DONE);
  assign status.trig_right = (line_r == LAST_LINE) && (phase_r == PHASE_RIGHT_DONE);
  assign status.out_free   = !out_valid_r || out_tready;

  assign waddr = AW'(int'(line_r) * MAX_MCUS + int'(mcu_r));
  assign raddr = AW'(int'(cmd.row) * MAX_MCUS + int'(mcu_rd_r));

  for (genvar b = 0; b < MCU_WIDTH; b++) begin : g_bank
    yrb_ram #(
      .WIDTH(PIXEL_W),
      .DEPTH(DEPTH)
    ) u_bank (
      .clk  (clk),
      .we   (cmd.wr_en && (phase_r == PHASE_W'(b))),
      .waddr(waddr),
      .wdata(in_tdata),
      .re   (cmd.rd_en),
      .raddr(raddr),
      .rdata(bank_rdata[b])
    );
  end

  always_comb begin
    row_sel = '0;
    for (int k = 0; k < BLOCK_SIZE; k++) begin
      case (cmd.kind)
        KIND_Y_LEFT:  row_sel[k*SAMPLE_W +: SAMPLE_W] = bank_rdata[k][7:0];
        KIND_Y_RIGHT: row_sel[k*SAMPLE_W +: SAMPLE_W] = bank_rdata[BLOCK_SIZE + k][7:0];
        KIND_U:       row_sel[k*SAMPLE_W +: SAMPLE_W] = bank_rdata[2 * k][15:8];
        KIND_V:       row_sel[k*SAMPLE_W +: SAMPLE_W] = bank_rdata[2 * k + 1][15:8];
        default:      row_sel[k*SAMPLE_W +: SAMPLE_W] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data_r <= row_sel;
      out_user_r <= {cmd.row, cmd.kind};
      out_last_r <= cmd.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule
